// ===== rtl/mie_pkg.sv =====
// ----------------------------------------------------------------------------
// mie_pkg
// Shared widths and the command and status types of the modular inverse block.
// ----------------------------------------------------------------------------
package mie_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FIELD_BITS = DATA_WIDTH - 1;
    localparam int COEF_BITS  = DATA_WIDTH;
    localparam int CNT_BITS   = $clog2(FIELD_BITS);
    localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(FIELD_BITS - 1);

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic mul;
        logic upd;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic r1_zero;
        logic div_last;
    } t_status;

endpackage

// ===== rtl/mie_ctrl.sv =====
// ----------------------------------------------------------------------------
// mie_ctrl
// Sequencer of the Euclid loop: division, multiply, update and final reduction.
// ----------------------------------------------------------------------------
module mie_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_out_free,
    input  mie_pkg::t_status i_status,
    output mie_pkg::t_cmd   o_cmd,
    output logic            o_busy
);
    import mie_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_DIV   = 6'b000100,
        S_MUL   = 6'b001000,
        S_UPD   = 6'b010000,
        S_RED   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.r1_zero) begin
                    n_state = S_RED;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_CHECK;
            end
            S_RED: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/mie_dp.sv =====
// ----------------------------------------------------------------------------
// mie_dp
// Remainder and coefficient registers, serial divider, multiplier, reduction.
// ----------------------------------------------------------------------------
module mie_dp (
    input  logic                             i_clk,
    input  mie_pkg::t_cmd                    i_cmd,
    input  logic [mie_pkg::FIELD_BITS-1:0]   i_operand,
    input  logic [mie_pkg::FIELD_BITS-1:0]   i_modulus,
    output mie_pkg::t_status                 o_status,
    output logic [mie_pkg::FIELD_BITS-1:0]   o_inverse,
    output logic                             o_invertible
);
    import mie_pkg::*;

    logic [FIELD_BITS-1:0]       r_r0;
    logic [FIELD_BITS-1:0]       r_r1;
    logic signed [COEF_BITS-1:0] r_s0;
    logic signed [COEF_BITS-1:0] r_s1;
    logic [FIELD_BITS-1:0]       r_rem;
    logic [FIELD_BITS-1:0]       r_quo;
    logic [CNT_BITS-1:0]         r_cnt;
    logic signed [COEF_BITS:0]   r_prod;

    logic [FIELD_BITS:0]           w_rem_sh;
    logic                          w_qbit;
    logic [FIELD_BITS:0]           w_rem_nx;
    logic signed [2*COEF_BITS-1:0] w_prod_full;
    logic signed [COEF_BITS:0]     w_s_diff;
    logic signed [COEF_BITS:0]     w_s0x;
    logic signed [COEF_BITS:0]     w_mx;
    logic signed [COEF_BITS:0]     w_red;

    assign w_rem_sh = {r_rem, r_quo[FIELD_BITS-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_r1});
    assign w_rem_nx = w_qbit ? (w_rem_sh - {1'b0, r_r1}) : w_rem_sh;

    assign w_prod_full = $signed({1'b0, r_quo}) * r_s1;
    assign w_s_diff    = {r_s0[COEF_BITS-1], r_s0} - r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r0 <= i_operand;
            r_r1 <= i_modulus;
            r_s0 <= COEF_BITS'(1);
            r_s1 <= '0;
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= r_r0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_rem_nx[FIELD_BITS-1:0];
            r_quo <= {r_quo[FIELD_BITS-2:0], w_qbit};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod_full[COEF_BITS:0];
        end
        if (i_cmd.upd) begin
            r_r0 <= r_r1;
            r_r1 <= r_rem;
            r_s0 <= r_s1;
            r_s1 <= w_s_diff[COEF_BITS-1:0];
        end
    end

    assign o_status.r1_zero  = (r_r1 == '0);
    assign o_status.div_last = (r_cnt == DIV_LAST);

    assign w_s0x = {r_s0[COEF_BITS-1], r_s0};
    assign w_mx  = $signed({2'b00, i_modulus});

    always_comb begin
        if (w_s0x < 0) begin
            w_red = w_s0x + w_mx;
        end else if (w_s0x >= w_mx) begin
            w_red = w_s0x - w_mx;
        end else begin
            w_red = w_s0x;
        end
    end

    assign o_inverse    = (i_modulus == '0) ? '0 : w_red[FIELD_BITS-1:0];
    assign o_invertible = (i_modulus != '0) && (r_r0 == FIELD_BITS'(1));

endmodule

// ===== rtl/modular_inverse_ext_euclid.sv =====
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid
// Modular inverse of an operand against a configured modulus.
// ----------------------------------------------------------------------------
// The input channel (i_valid, o_stall, i_operand) takes one operand per
// transaction. The output channel (o_valid, i_stall, o_inverse, o_invertible)
// returns one result per operand, in order. The modulus is written through
// i_cfg_we and i_cfg_data and resets to two. The user must write it only
// while the block is idle; the block itself does not enforce this.
// Each Euclid step runs a restoring division of one quotient bit per cycle,
// one check, one registered multiply and one update. The next operand is
// accepted once the controller is back in idle after the final reduction.
// Only one operand is in work at a time. The finished result sits in an
// output register, so the next operand is accepted while it waits.
// When the receiver stalls, the result register holds and the loop waits
// with a finished item until the register is free again.
// Reset clears the controller and the output valid flag and sets the
// modulus to two.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [mie_pkg::FIELD_BITS-1:0] i_operand,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [mie_pkg::FIELD_BITS-1:0] o_inverse,
    output logic                           o_invertible,
    input  logic                           i_cfg_we,
    input  logic [mie_pkg::FIELD_BITS-1:0] i_cfg_data
);
    import mie_pkg::*;

    logic [FIELD_BITS-1:0] r_modulus;
    logic                  r_out_valid;
    logic [FIELD_BITS-1:0] r_inverse;
    logic                  r_invertible;

    t_cmd                  w_cmd;
    t_status               w_status;
    logic                  w_busy;
    logic                  w_out_free;
    logic [FIELD_BITS-1:0] w_inverse;
    logic                  w_invertible;

    assign w_out_free = !r_out_valid || !i_stall;

    mie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    mie_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_operand    (i_operand),
        .i_modulus    (r_modulus),
        .o_status     (w_status),
        .o_inverse    (w_inverse),
        .o_invertible (w_invertible)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= FIELD_BITS'(2);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_modulus <= i_cfg_data;
            end
            if (w_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.finish) begin
            r_inverse    <= w_inverse;
            r_invertible <= w_invertible;
        end
    end

    assign o_stall      = w_busy;
    assign o_valid      = r_out_valid;
    assign o_inverse    = r_inverse;
    assign o_invertible = r_invertible;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("Block not busy after an accepted transaction.");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> (!r_out_valid || !i_stall))
        else $error("Result written over a waiting transaction.");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !w_cmd.finish) |=> !o_valid)
        else $error("Result delivered twice.");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invertible) |-> (o_inverse < r_modulus))
        else $error("Inverse not reduced below the modulus.");

endmodule
